@@ src/waypoint_heading_controller_macros.svh @@
// Assertion shorthands for the waypoint heading controller.
// Each check samples on clk and is held off while rst_n is low.
`ifndef WAYPOINT_HEADING_CONTROLLER_MACROS_SVH
`define WAYPOINT_HEADING_CONTROLLER_MACROS_SVH

// Same-cycle implication.
`define WHC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WHC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/whc_pkg.sv @@
package whc_pkg;

  // CORDIC datapath width: holds a 17-bit position difference scaled by 2^20 plus gain
  localparam int DW = 40;
  // angle accumulator, Q.24 radians
  localparam int ZW = 28;
  localparam int ANG_FRAC_SHIFT = 12;
  localparam int POS_SHIFT = 20;

  typedef logic signed [DW-1:0] cval_t;
  typedef logic signed [ZW-1:0] zval_t;

  localparam zval_t HALF_PI_Q24 = 28'sd26353589;
  localparam zval_t ROUND_HALF = 28'sd2048;
  localparam cval_t ONE_Q28 = 40'sd268435456;

  // request opcodes
  localparam logic OP_ODOM = 1'b0;
  localparam logic OP_IMU  = 1'b1;

  // configuration register indexes
  localparam logic [2:0] CFG_MID_GOAL_X       = 3'd0;
  localparam logic [2:0] CFG_MID_GOAL_Y       = 3'd1;
  localparam logic [2:0] CFG_FINAL_GOAL_X     = 3'd2;
  localparam logic [2:0] CFG_FINAL_GOAL_Y     = 3'd3;
  localparam logic [2:0] CFG_HEADING_DEADBAND = 3'd4;
  localparam logic [2:0] CFG_GOAL_TOLERANCE   = 3'd5;
  localparam logic [2:0] CFG_TURN_RATE        = 3'd6;
  localparam logic [2:0] CFG_FORWARD_SPEED    = 3'd7;

  // atan(2^-i) in Q.24 radians
  function automatic zval_t atan_q24(input logic [4:0] idx);
    case (idx)
      5'd0:  return 28'sd13176795;
      5'd1:  return 28'sd7778716;
      5'd2:  return 28'sd4110060;
      5'd3:  return 28'sd2086331;
      5'd4:  return 28'sd1047214;
      5'd5:  return 28'sd524117;
      5'd6:  return 28'sd262123;
      5'd7:  return 28'sd131069;
      5'd8:  return 28'sd65536;
      5'd9:  return 28'sd32768;
      5'd10: return 28'sd16384;
      5'd11: return 28'sd8192;
      5'd12: return 28'sd4096;
      5'd13: return 28'sd2048;
      5'd14: return 28'sd1024;
      5'd15: return 28'sd512;
      5'd16: return 28'sd256;
      5'd17: return 28'sd128;
      5'd18: return 28'sd64;
      5'd19: return 28'sd32;
      5'd20: return 28'sd16;
      5'd21: return 28'sd8;
      5'd22: return 28'sd4;
      5'd23: return 28'sd2;
      default: return '0;
    endcase
  endfunction

endpackage

@@ src/waypoint_heading_controller.sv @@
// Odometry request: accepted in S_IDLE, stores the position, no result.
// IMU request: S_MUL forms four products with one multiplier, then one CORDIC unit
// gives the yaw (S_YAW_LOAD, S_ROT) and the bearing (S_BRG_LOAD, S_ROT) in turn,
// and S_DECIDE sets the drive command shown in S_CMD. One request at a time: in_stall
// stays high until the last result is taken, so no new request is accepted meanwhile.
// Synchronous active-low reset clears position, goal stage and loads default config.
`include "waypoint_heading_controller_macros.svh"

module waypoint_heading_controller
  import whc_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic signed [15:0] in_quat_w,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic        [14:0] out_linear_speed,
  output logic signed [15:0] out_angular_rate,
  output logic               out_goal_reached,
  output logic               out_last,
  // configuration
  input  logic               cfg_we,
  input  logic         [2:0] cfg_index,
  input  logic        [15:0] cfg_data
);

  localparam int CNT_W = $clog2(CORDIC_STEPS);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CORDIC_STEPS - 1);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_MUL      = 8'b0000_0010,
    S_YAW_LOAD = 8'b0000_0100,
    S_ROT      = 8'b0000_1000,
    S_BRG_LOAD = 8'b0001_0000,
    S_DECIDE   = 8'b0010_0000,
    S_CMD      = 8'b0100_0000,
    S_STOP     = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic signed [15:0] mid_x_r, mid_x_nxt, mid_y_r, mid_y_nxt;
  logic signed [15:0] fin_x_r, fin_x_nxt, fin_y_r, fin_y_nxt;
  logic        [13:0] db_r, db_nxt;
  logic        [14:0] tol_r, tol_nxt, turn_r, turn_nxt, fwd_r, fwd_nxt;

  // block state
  logic signed [15:0] robot_x_r, robot_x_nxt, robot_y_r, robot_y_nxt;
  logic               stage_r, stage_nxt;

  // request payload held for the multiply sequence
  logic signed [15:0] qx_r, qx_nxt, qy_r, qy_nxt, qz_r, qz_nxt, qw_r, qw_nxt;

  // multiply sequence: acc_a = wz + xy, acc_b = yy + zz
  logic         [1:0] mcnt_r, mcnt_nxt;
  logic signed [32:0] acc_a_r, acc_a_nxt, acc_b_r, acc_b_nxt;
  logic signed [15:0] mul_a, mul_b;
  logic signed [31:0] prod;

  // CORDIC unit
  cval_t              cx_r, cx_nxt, cy_r, cy_nxt;
  zval_t              cz_r, cz_nxt;
  logic   [CNT_W-1:0] iter_r, iter_nxt;
  logic               zero_r, zero_nxt;
  logic               pass_r, pass_nxt;  // 0: yaw, 1: bearing
  cval_t              ld_x, ld_y, xs, ys;
  zval_t              at, rnd;
  logic signed [15:0] ang_w;

  logic signed [15:0] yaw_r, yaw_nxt;

  // bearing operands
  logic signed [15:0] gx_w, gy_w;
  logic signed [16:0] dx_w, dy_w;
  cval_t              num_w, den_w;

  // decision
  logic signed [17:0] diff_w, db_s, tol_s, gx_s, gy_s, rx_s, ry_s;
  logic               hit_w;
  logic        [14:0] lin_r, lin_nxt;
  logic signed [15:0] ang_r, ang_nxt;
  logic               hit_r, hit_nxt;

  logic in_acc, out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = (state_r == S_CMD) || (state_r == S_STOP);
  assign out_linear_speed = (state_r == S_CMD) ? lin_r : '0;
  assign out_angular_rate = (state_r == S_CMD) ? ang_r : '0;
  assign out_goal_reached = (state_r == S_STOP);
  assign out_last         = (state_r == S_STOP) || !hit_r;

  // shared multiplier, one product per cycle
  always_comb begin
    case (mcnt_r)
      2'd0:    begin mul_a = qw_r; mul_b = qz_r; end
      2'd1:    begin mul_a = qx_r; mul_b = qy_r; end
      2'd2:    begin mul_a = qy_r; mul_b = qy_r; end
      default: begin mul_a = qz_r; mul_b = qz_r; end
    endcase
  end
  assign prod = mul_a * mul_b;

  // yaw terms: num = 2(wz + xy), den = 1 - 2(yy + zz), Q2.28
  assign num_w = cval_t'(acc_a_r) <<< 1;
  assign den_w = ONE_Q28 - (cval_t'(acc_b_r) <<< 1);

  // bearing terms: goal minus position, scaled by 2^20
  assign gx_w = stage_r ? fin_x_r : mid_x_r;
  assign gy_w = stage_r ? fin_y_r : mid_y_r;
  assign dx_w = 17'(gx_w) - 17'(robot_x_r);
  assign dy_w = 17'(gy_w) - 17'(robot_y_r);

  assign ld_x = (state_r == S_YAW_LOAD) ? den_w : (cval_t'(dx_w) <<< POS_SHIFT);
  assign ld_y = (state_r == S_YAW_LOAD) ? num_w : (cval_t'(dy_w) <<< POS_SHIFT);

  // one micro-rotation per cycle
  assign xs = cx_r >>> iter_r;
  assign ys = cy_r >>> iter_r;
  assign at = atan_q24(5'(iter_r));

  // round half up to Q3.12; a zero vector gives angle zero
  assign rnd   = (cz_r + ROUND_HALF) >>> ANG_FRAC_SHIFT;
  assign ang_w = zero_r ? '0 : 16'(rnd);

  // heading error, not wrapped
  assign diff_w = 18'(ang_w) - 18'(yaw_r);
  assign db_s   = $signed({4'b0, db_r});

  // goal box, strict on every side
  assign tol_s = $signed({3'b0, tol_r});
  assign gx_s  = 18'(gx_w);
  assign gy_s  = 18'(gy_w);
  assign rx_s  = 18'(robot_x_r);
  assign ry_s  = 18'(robot_y_r);
  assign hit_w = (rx_s > gx_s - tol_s) && (rx_s < gx_s + tol_s) &&
                 (ry_s > gy_s - tol_s) && (ry_s < gy_s + tol_s);

  always_comb begin
    state_nxt   = state_r;
    mid_x_nxt   = mid_x_r;
    mid_y_nxt   = mid_y_r;
    fin_x_nxt   = fin_x_r;
    fin_y_nxt   = fin_y_r;
    db_nxt      = db_r;
    tol_nxt     = tol_r;
    turn_nxt    = turn_r;
    fwd_nxt     = fwd_r;
    robot_x_nxt = robot_x_r;
    robot_y_nxt = robot_y_r;
    stage_nxt   = stage_r;
    qx_nxt      = qx_r;
    qy_nxt      = qy_r;
    qz_nxt      = qz_r;
    qw_nxt      = qw_r;
    mcnt_nxt    = mcnt_r;
    acc_a_nxt   = acc_a_r;
    acc_b_nxt   = acc_b_r;
    cx_nxt      = cx_r;
    cy_nxt      = cy_r;
    cz_nxt      = cz_r;
    iter_nxt    = iter_r;
    zero_nxt    = zero_r;
    pass_nxt    = pass_r;
    yaw_nxt     = yaw_r;
    lin_nxt     = lin_r;
    ang_nxt     = ang_r;
    hit_nxt     = hit_r;

    // register writes take effect at once; the host must write only while idle, the block does not enforce it
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MID_GOAL_X:       mid_x_nxt = $signed(cfg_data);
        CFG_MID_GOAL_Y:       mid_y_nxt = $signed(cfg_data);
        CFG_FINAL_GOAL_X:     fin_x_nxt = $signed(cfg_data);
        CFG_FINAL_GOAL_Y:     fin_y_nxt = $signed(cfg_data);
        CFG_HEADING_DEADBAND: db_nxt    = cfg_data[13:0];
        CFG_GOAL_TOLERANCE:   tol_nxt   = cfg_data[14:0];
        CFG_TURN_RATE:        turn_nxt  = cfg_data[14:0];
        CFG_FORWARD_SPEED:    fwd_nxt   = cfg_data[14:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_ODOM) begin
            // store position, no result
            robot_x_nxt = in_pos_x;
            robot_y_nxt = in_pos_y;
          end else begin
            qx_nxt    = in_quat_x;
            qy_nxt    = in_quat_y;
            qz_nxt    = in_quat_z;
            qw_nxt    = in_quat_w;
            mcnt_nxt  = '0;
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        // accumulate four products, two per sum
        case (mcnt_r)
          2'd0:    acc_a_nxt = 33'(prod);
          2'd1:    acc_a_nxt = acc_a_r + 33'(prod);
          2'd2:    acc_b_nxt = 33'(prod);
          default: acc_b_nxt = acc_b_r + 33'(prod);
        endcase
        mcnt_nxt = mcnt_r + 2'd1;
        if (mcnt_r == 2'd3) begin
          state_nxt = S_YAW_LOAD;
        end
      end
      S_YAW_LOAD, S_BRG_LOAD: begin
        if (state_r == S_BRG_LOAD) begin
          yaw_nxt = ang_w;
        end
        pass_nxt = (state_r == S_BRG_LOAD);
        zero_nxt = (ld_x == '0) && (ld_y == '0);
        iter_nxt = '0;
        // fold the left half-plane onto the right
        if (ld_x < 0) begin
          if (ld_y >= 0) begin
            cx_nxt = ld_y;
            cy_nxt = -ld_x;
            cz_nxt = HALF_PI_Q24;
          end else begin
            cx_nxt = -ld_y;
            cy_nxt = ld_x;
            cz_nxt = -HALF_PI_Q24;
          end
        end else begin
          cx_nxt = ld_x;
          cy_nxt = ld_y;
          cz_nxt = '0;
        end
        state_nxt = S_ROT;
      end
      S_ROT: begin
        // drive y toward zero
        if (cy_r >= 0) begin
          cx_nxt = cx_r + ys;
          cy_nxt = cy_r - xs;
          cz_nxt = cz_r + at;
        end else begin
          cx_nxt = cx_r - ys;
          cy_nxt = cy_r + xs;
          cz_nxt = cz_r - at;
        end
        iter_nxt = iter_r + CNT_W'(1);
        if (iter_r == LAST_STEP) begin
          state_nxt = pass_r ? S_DECIDE : S_BRG_LOAD;
        end
      end
      S_DECIDE: begin
        lin_nxt = '0;
        ang_nxt = '0;
        if (diff_w > db_s) begin
          ang_nxt = $signed({1'b0, turn_r});
        end else if (diff_w < -db_s) begin
          ang_nxt = -$signed({1'b0, turn_r});
        end else begin
          lin_nxt = fwd_r;
        end
        hit_nxt = hit_w;
        if (hit_w) begin
          stage_nxt = 1'b1;
        end
        state_nxt = S_CMD;
      end
      S_CMD: begin
        if (out_acc) begin
          state_nxt = hit_r ? S_STOP : S_IDLE;
        end
      end
      S_STOP: begin
        if (out_acc) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      mid_x_r   <= 16'sd0;
      mid_y_r   <= 16'sd512;
      fin_x_r   <= 16'sd512;
      fin_y_r   <= 16'sd512;
      db_r      <= 14'd82;
      tol_r     <= 15'd51;
      turn_r    <= 15'd410;
      fwd_r     <= 15'd51;
      robot_x_r <= '0;
      robot_y_r <= '0;
      stage_r   <= 1'b0;
      mcnt_r    <= '0;
      iter_r    <= '0;
      pass_r    <= 1'b0;
      hit_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      mid_x_r   <= mid_x_nxt;
      mid_y_r   <= mid_y_nxt;
      fin_x_r   <= fin_x_nxt;
      fin_y_r   <= fin_y_nxt;
      db_r      <= db_nxt;
      tol_r     <= tol_nxt;
      turn_r    <= turn_nxt;
      fwd_r     <= fwd_nxt;
      robot_x_r <= robot_x_nxt;
      robot_y_r <= robot_y_nxt;
      stage_r   <= stage_nxt;
      mcnt_r    <= mcnt_nxt;
      iter_r    <= iter_nxt;
      pass_r    <= pass_nxt;
      hit_r     <= hit_nxt;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    qx_r    <= qx_nxt;
    qy_r    <= qy_nxt;
    qz_r    <= qz_nxt;
    qw_r    <= qw_nxt;
    acc_a_r <= acc_a_nxt;
    acc_b_r <= acc_b_nxt;
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    cz_r    <= cz_nxt;
    zero_r  <= zero_nxt;
    yaw_r   <= yaw_nxt;
    lin_r   <= lin_nxt;
    ang_r   <= ang_nxt;
  end

  // a stop result only follows a box hit, which moves the goal to the final one
  `WHC_ASSERT_NOW(a_stop_after_hit, state_r == S_STOP, hit_r && stage_r, "stop without goal hit")
  // a taken command that is not last is followed by the stop result
  `WHC_ASSERT_NEXT(a_stop_follows, out_acc && !out_last, out_valid && out_goal_reached,
                   "stop result missing after command")
  // a drive command either turns or goes forward, never both
  `WHC_ASSERT_NOW(a_cmd_exclusive, out_valid && !out_goal_reached,
                  out_linear_speed == '0 || out_angular_rate == '0, "turn and drive together")
  // no new request while a result is pending
  `WHC_ASSERT_NOW(a_no_accept_busy, out_valid, in_stall, "request accepted with result pending")

endmodule

@@ sim/waypoint_heading_controller_tb.sv @@
module waypoint_heading_controller_tb
  import whc_pkg::*;
();

  localparam int STEPS = 16;
  localparam int CYCLE_LIMIT = 1000000;
  // wait long enough for an IMU request to finish before touching registers
  localparam int SETTLE_CYCLES = 2 * STEPS + 12;
  localparam int MAX_WAIT = 13;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 322;
  localparam int REPORT_LIMIT = 10;
  localparam longint RIGHT_ANGLE_Q24 = 64'sd26353589;

  typedef struct {
    logic               op;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
  } sensor_req_t;

  typedef struct {
    logic        [14:0] lin;
    logic signed [15:0] ang;
    logic               stop;
    logic               last;
  } drive_cmd_t;

  // atan(2^-i), Q.24 radians
  longint atan_step [0:23] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_op;
  logic signed [15:0] in_pos_x;
  logic signed [15:0] in_pos_y;
  logic signed [15:0] in_quat_x;
  logic signed [15:0] in_quat_y;
  logic signed [15:0] in_quat_z;
  logic signed [15:0] in_quat_w;
  logic               out_valid;
  logic               out_stall;
  logic        [14:0] out_linear_speed;
  logic signed [15:0] out_angular_rate;
  logic               out_goal_reached;
  logic               out_last;
  logic               cfg_we;
  logic         [2:0] cfg_index;
  logic        [15:0] cfg_data;

  // shadow copy of the register file and the controller state
  int goal_mid_x, goal_mid_y, goal_fin_x, goal_fin_y;
  int deadband, tolerance, turn_rate, fwd_speed;
  int robot_x, robot_y;
  bit on_final_leg;

  drive_cmd_t drive_cmd_q [$];
  drive_cmd_t want;
  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  rx_hold = 0;
  bit  calm = 1'b0;

  waypoint_heading_controller #(.CORDIC_STEPS(STEPS)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_quat_x        (in_quat_x),
    .in_quat_y        (in_quat_y),
    .in_quat_z        (in_quat_z),
    .in_quat_w        (in_quat_w),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_linear_speed (out_linear_speed),
    .out_angular_rate (out_angular_rate),
    .out_goal_reached (out_goal_reached),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Small helpers
  // ---------------------------------------------------------------------------

  // Idle cycles before the next request or result; zero during calm stretches.
  function automatic int draw_wait();
    if (calm) return 0;
    return int'($urandom_range(0, MAX_WAIT));
  endfunction

  function automatic int srange(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // Vectoring CORDIC atan2, result rounded half up to Q3.12.
  function automatic int cordic_angle(longint vy, longint vx);
    longint z, t, dx, dy;
    int     i;
    z = 0;
    if (vx == 0 && vy == 0) return 0;
    // fold the left half plane onto the right one by a quarter turn
    if (vx < 0) begin
      if (vy >= 0) begin
        t = vx; vx = vy; vy = -t; z = RIGHT_ANGLE_Q24;
      end else begin
        t = vx; vx = -vy; vy = t; z = -RIGHT_ANGLE_Q24;
      end
    end
    for (i = 0; i < STEPS; i++) begin
      dx = vx >>> i;
      dy = vy >>> i;
      if (vy >= 0) begin
        vx += dy; vy -= dx; z += atan_step[i];
      end else begin
        vx -= dy; vy += dx; z -= atan_step[i];
      end
    end
    return int'((z + 64'sd2048) >>> 12);
  endfunction

  // Work out the drive commands that one accepted request leads to.
  function automatic void predict_drive(sensor_req_t r);
    longint     qx, qy, qz, qw, num, den;
    int         yaw, bearing, diff, gx, gy, lin, ang;
    bit         hit;
    drive_cmd_t cmd;
    if (r.op == OP_ODOM) begin
      robot_x = int'(r.pos_x);
      robot_y = int'(r.pos_y);
      return;
    end
    qx = longint'(r.qx);
    qy = longint'(r.qy);
    qz = longint'(r.qz);
    qw = longint'(r.qw);
    num = 2 * (qw * qz + qx * qy);
    den = (longint'(1) << 28) - 2 * (qy * qy + qz * qz);
    yaw = cordic_angle(num, den);

    gx = on_final_leg ? goal_fin_x : goal_mid_x;
    gy = on_final_leg ? goal_fin_y : goal_mid_y;
    bearing = cordic_angle(longint'(gy - robot_y) * (longint'(1) << 20),
                           longint'(gx - robot_x) * (longint'(1) << 20));

    // bearing minus yaw is deliberately left unwrapped
    diff = bearing - yaw;
    lin = 0;
    ang = 0;
    if (diff > deadband) ang = turn_rate;
    else if (diff < -deadband) ang = -turn_rate;
    else lin = fwd_speed;

    // strict box on both axes; zero tolerance can never match
    hit = robot_x > gx - tolerance && robot_x < gx + tolerance &&
          robot_y > gy - tolerance && robot_y < gy + tolerance;

    cmd.lin  = lin[14:0];
    cmd.ang  = ang[15:0];
    cmd.stop = 1'b0;
    cmd.last = !hit;
    drive_cmd_q.push_back(cmd);
    if (hit) begin
      cmd.lin  = '0;
      cmd.ang  = '0;
      cmd.stop = 1'b1;
      cmd.last = 1'b1;
      drive_cmd_q.push_back(cmd);
      on_final_leg = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Present one request after a random gap, hold it until taken, then predict.
  task automatic send_request(sensor_req_t r);
    int gap;
    gap = draw_wait();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_op     <= r.op;
    in_pos_x  <= r.pos_x;
    in_pos_y  <= r.pos_y;
    in_quat_x <= r.qx;
    in_quat_y <= r.qy;
    in_quat_z <= r.qz;
    in_quat_w <= r.qw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_drive(r);
  endtask

  task automatic send_odom(int x, int y);
    sensor_req_t r;
    r.op    = OP_ODOM;
    r.pos_x = x[15:0];
    r.pos_y = y[15:0];
    r.qx    = 16'($urandom());
    r.qy    = 16'($urandom());
    r.qz    = 16'($urandom());
    r.qw    = 16'($urandom());
    send_request(r);
  endtask

  task automatic send_imu(int x, int y, int z, int w);
    sensor_req_t r;
    r.op    = OP_IMU;
    r.pos_x = 16'($urandom());
    r.pos_y = 16'($urandom());
    r.qx    = x[15:0];
    r.qy    = y[15:0];
    r.qz    = z[15:0];
    r.qw    = w[15:0];
    send_request(r);
  endtask

  // Drop valid and hold off until every expected command has been taken,
  // plus enough cycles for a request that produces nothing.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (drive_cmd_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[15:0];
    case (idx)
      CFG_MID_GOAL_X:       goal_mid_x = int'($signed(value[15:0]));
      CFG_MID_GOAL_Y:       goal_mid_y = int'($signed(value[15:0]));
      CFG_FINAL_GOAL_X:     goal_fin_x = int'($signed(value[15:0]));
      CFG_FINAL_GOAL_Y:     goal_fin_y = int'($signed(value[15:0]));
      CFG_HEADING_DEADBAND: deadband   = int'(value[13:0]);
      CFG_GOAL_TOLERANCE:   tolerance  = int'(value[14:0]);
      CFG_TURN_RATE:        turn_rate  = int'(value[14:0]);
      CFG_FORWARD_SPEED:    fwd_speed  = int'(value[14:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(int mx, int my, int fx, int fy, int band, int tol, int turn,
                           int fwd);
    write_reg(CFG_MID_GOAL_X, mx);
    write_reg(CFG_MID_GOAL_Y, my);
    write_reg(CFG_FINAL_GOAL_X, fx);
    write_reg(CFG_FINAL_GOAL_Y, fy);
    write_reg(CFG_HEADING_DEADBAND, band);
    write_reg(CFG_GOAL_TOLERANCE, tol);
    write_reg(CFG_TURN_RATE, turn);
    write_reg(CFG_FORWARD_SPEED, fwd);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Stall each result for its drawn number of valid cycles.
  always @(negedge clk) begin
    out_stall <= (rx_hold > 0);
    if (rx_hold > 0 && out_valid) rx_hold <= rx_hold - 1;
  end

  // Compare every taken command against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (drive_cmd_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected command: lin=%0d ang=%0d stop=%0b last=%0b",
                   out_linear_speed, out_angular_rate, out_goal_reached, out_last);
      end else begin
        want = drive_cmd_q.pop_front();
        if (out_linear_speed !== want.lin || out_angular_rate !== want.ang ||
            out_goal_reached !== want.stop || out_last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("command mismatch: lin %0d/%0d ang %0d/%0d stop %0b/%0b last %0b/%0b",
                     want.lin, out_linear_speed, want.ang, out_angular_rate,
                     want.stop, out_goal_reached, want.last, out_last);
        end
      end
      rx_hold <= draw_wait();
    end
  end

  // Watchdog: give up if the run stalls.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL waypoint_heading_controller");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Default registers, robot at origin heading to the first waypoint.
  task automatic test_power_on_defaults();
    send_imu(0, 0, 0, 16384);            // yaw zero, goal straight left
    send_imu(0, 0, 0, 0);                // degenerate quaternion, den stays one, so yaw zero
    send_imu(0, 16384, 0, 0);            // yaw on the negative x axis, +pi
    send_imu(0, 0, 11585, 11585);        // yaw near pi/2, aligned
    send_imu(-32768, -32768, -32768, -32768);
    send_imu(32767, 32767, 32767, 32767);
    send_imu(16384, -16384, 16384, -16384);
  endtask

  // Register extremes: corner goals, widest deadband, zero tolerance.
  task automatic test_register_extremes();
    settle();
    write_all(-32768, 32767, 32767, -32768, 12868, 0, 32767, 32767);
    send_odom(-32768, 32767);            // on the goal, but zero tolerance never hits
    send_imu(0, 0, 0, 16384);
    send_odom(32767, 32767);             // goal dead behind, bearing +pi
    send_imu(0, 0, 0, 16384);
    send_imu(0, 0, 16384, 0);
    settle();
    write_reg(CFG_HEADING_DEADBAND, 0);
    write_reg(CFG_TURN_RATE, 0);
    send_imu(0, 0, 0, 16384);            // turn with zero rate
  endtask

  // Goal box edges, the switch to the final goal and reaching it again.
  task automatic test_goal_box();
    settle();
    write_all(100, 100, -200, 300, 82, 1, 410, 51);
    send_odom(100, 100);
    send_imu(0, 0, 0, 16384);            // inside the first box: stop follows
    send_odom(-200, 300);
    send_imu(0, 0, 0, 16384);            // final goal reached, stop again
    send_odom(-199, 300);
    send_imu(0, 0, 0, 16384);            // on the box edge: strict, no stop
  endtask

  function automatic sensor_req_t make_random_request();
    sensor_req_t r;
    int          k, span, gx, gy;
    r.pos_x = 16'($urandom());
    r.pos_y = 16'($urandom());
    r.qx    = 16'($urandom());
    r.qy    = 16'($urandom());
    r.qz    = 16'($urandom());
    r.qw    = 16'($urandom());
    r.op    = ($urandom_range(0, 9) < 4) ? OP_ODOM : OP_IMU;
    if (r.op == OP_ODOM) begin
      // mostly land around the active goal so the box test flips both ways
      if ($urandom_range(0, 9) < 7) begin
        gx = on_final_leg ? goal_fin_x : goal_mid_x;
        gy = on_final_leg ? goal_fin_y : goal_mid_y;
        span = 2 * tolerance + 2;
        if (span > 20000) span = 20000;
        r.pos_x = 16'(gx + srange(-span, span));
        r.pos_y = 16'(gy + srange(-span, span));
      end
    end else begin
      k = $urandom_range(0, 9);
      if (k < 6) begin
        // mostly planar rotations, small tilt
        r.qx = 16'(srange(-1500, 1500));
        r.qy = 16'(srange(-1500, 1500));
        r.qz = 16'(srange(-16384, 16384));
        r.qw = 16'(srange(-16384, 16384));
      end else if (k < 9) begin
        r.qx = 16'(srange(-16384, 16384));
        r.qy = 16'(srange(-16384, 16384));
        r.qz = 16'(srange(-16384, 16384));
        r.qw = 16'(srange(-16384, 16384));
      end
      // else keep the raw 16-bit values, out of range included
    end
    return r;
  endfunction

  // Phases of random traffic, each under its own register setting.
  task automatic test_random_traffic();
    int phase, n, fx, fy, band, tol, turn, fwd;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      if (phase % 2 == 0) begin
        fx = srange(-4000, 4000);
        fy = srange(-4000, 4000);
      end else begin
        fx = srange(-32768, 32767);
        fy = srange(-32768, 32767);
      end
      case (phase % 4)
        0: band = 0;
        1: band = 12868;
        2: band = srange(0, 400);
        default: band = srange(0, 12868);
      endcase
      case (phase % 3)
        0: tol = srange(1, 3000);
        1: tol = srange(0, 300);
        default: tol = 32767;
      endcase
      turn = (phase == 1) ? 32767 : srange(0, 32767);
      fwd  = (phase == 4) ? 0 : srange(0, 32767);
      write_all(srange(-32768, 32767), srange(-32768, 32767), fx, fy, band, tol, turn, fwd);
      calm = (phase == 2);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // hold off mid-phase until the pipeline has drained
        if (phase == 3 && n == ITEMS_PER_PHASE / 2) settle();
        send_request(make_random_request());
      end
      calm = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_op     = OP_ODOM;
    in_pos_x  = '0;
    in_pos_y  = '0;
    in_quat_x = '0;
    in_quat_y = '0;
    in_quat_z = '0;
    in_quat_w = '0;
    out_stall = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_MID_GOAL_X;
    cfg_data  = '0;

    // power-on register values and state
    goal_mid_x = 0;
    goal_mid_y = 512;
    goal_fin_x = 512;
    goal_fin_y = 512;
    deadband   = 82;
    tolerance  = 51;
    turn_rate  = 410;
    fwd_speed  = 51;
    robot_x    = 0;
    robot_y    = 0;
    on_final_leg = 1'b0;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_power_on_defaults();
    test_register_extremes();
    test_goal_box();
    test_random_traffic();

    settle();
    if (mismatch_count == 0) begin
      $display("PASS waypoint_heading_controller");
    end else begin
      $display("FAIL waypoint_heading_controller");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/whc_pkg.sv
src/waypoint_heading_controller.sv
sim/waypoint_heading_controller_tb.sv
